/* design/bmg_pkg.sv */
// Shared types, constants and tables for the Box-Muller Gaussian sample unit.
package bmg_pkg;

  localparam int UNIFORM_BITS_DEF = 32;
  localparam int LOG_ROUNDS       = 30;
  localparam int CORDIC_ROUNDS    = 28;
  localparam int SQRT_ROUNDS      = 32;

  localparam logic [28:0]        TWO_LN2_Q28    = 29'd372130559;
  localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
  localparam logic [31:0]        QUARTER_TURN   = 32'h4000_0000;
  localparam logic [31:0]        HALF_TURN      = 32'h8000_0000;

  typedef enum logic [0:0] {
    REG_MEAN = 1'b0,
    REG_STD  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] normal_sample;
    logic               saturated;
  } out_item_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] turn_atan(input int idx);
    logic [29:0] a;
    case (idx)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

/* design/box_muller_gaussian_unit.sv */
// Box-Muller Gaussian sample unit: cosine branch, fully pipelined.
// The unit takes one pair of uniform fractions per clock while the pipeline advances and
// returns one signed Q16.16 sample per clock, sqrt(-2 ln u1) * cos(2 pi u2) * std_deviation +
// mean_value, saturated to 32 bits. The pipeline has 69 stages plus the output register;
// its depth is set by the 30 squaring stages of the logarithm and the 32 stages of the square
// root, with the 28 CORDIC rotations running alongside the logarithm. The whole pipeline
// advances whenever the output register is empty or its result is being transferred, so a new
// item may be transferred in every such cycle. A radius of zero yields mean_value exactly.
module box_muller_gaussian_unit #(
  parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmg_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int LR = bmg_pkg::LOG_ROUNDS;
  localparam int CR = bmg_pkg::CORDIC_ROUNDS;
  localparam int SR = bmg_pkg::SQRT_ROUNDS;
  localparam int NV = LR + SR + 7;
  localparam int LW = $clog2(UNIFORM_BITS);

  logic               en;
  logic [NV-1:0]      vld;
  logic signed [31:0] mean_value;
  logic [31:0]        std_deviation;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value    <= '0;
      std_deviation <= 32'd65536;
    end else if (cfg_we) begin
      unique case (bmg_pkg::cfg_reg_t'(cfg_index))
        bmg_pkg::REG_MEAN: mean_value    <= cfg_data;
        bmg_pkg::REG_STD:  std_deviation <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  // Input capture.
  logic [UNIFORM_BITS-1:0] rad0;
  logic [31:0]             ph0;

  always_ff @(posedge clk) begin
    if (en) begin
      rad0 <= in_data.uniform_radius[UNIFORM_BITS-1:0];
      ph0  <= 32'(in_data.uniform_angle[UNIFORM_BITS-1:0]) << (32 - UNIFORM_BITS);
    end
  end

  // Normalisation of the radius and folding of the angle.
  logic [LW-1:0]      lead;
  logic [31:0]        m_init;
  logic [5:0]         exp_init;
  logic [31:0]        fold;
  logic [31:0]        ph_fold;
  logic               neg_init;

  always_comb begin
    lead = '0;
    for (int b = 0; b < UNIFORM_BITS; b++) begin
      if (rad0[b]) begin
        lead = LW'(b);
      end
    end
  end

  assign m_init   = 32'(rad0) << (5'd31 - 5'(lead));
  assign exp_init = 6'(UNIFORM_BITS) - 6'(lead);
  assign fold     = ph0 + bmg_pkg::QUARTER_TURN;
  assign neg_init = fold[31];
  assign ph_fold  = neg_init ? ph0 - bmg_pkg::HALF_TURN : ph0;

  logic [31:0]        lm   [0:LR];
  logic [29:0]        lfr  [0:LR];
  logic [5:0]         lex  [0:LR];
  logic               lzr  [0:LR];
  logic signed [33:0] cx   [0:LR];
  logic signed [33:0] cy   [0:LR];
  logic signed [33:0] cz   [0:LR];
  logic               cng  [0:LR];

  always_ff @(posedge clk) begin
    if (en) begin
      lm[0]  <= m_init;
      lfr[0] <= '0;
      lex[0] <= exp_init;
      lzr[0] <= (rad0 == '0);
      cx[0]  <= bmg_pkg::CORDIC_GAIN;
      cy[0]  <= '0;
      cz[0]  <= $signed({{2{ph_fold[31]}}, ph_fold});
      cng[0] <= neg_init;
    end
  end

  // Each stage squares the mantissa for one fractional bit of the logarithm and, for the
  // first rounds, performs one CORDIC rotation on the angle.
  for (genvar r = 0; r < LR; r++) begin : g_log
    logic [63:0] sq;
    logic [32:0] sh;

    assign sq = 64'(lm[r]) * 64'(lm[r]);
    assign sh = sq[63:31];

    always_ff @(posedge clk) begin
      if (en) begin
        if (sh[32]) begin
          lm[r+1]  <= sh[32:1];
          lfr[r+1] <= lfr[r] | (30'(1) << (LR - 1 - r));
        end else begin
          lm[r+1]  <= sh[31:0];
          lfr[r+1] <= lfr[r];
        end
        lex[r+1] <= lex[r];
        lzr[r+1] <= lzr[r];
        cng[r+1] <= cng[r];
      end
    end

    if (r < CR) begin : g_rot
      localparam logic signed [33:0] ATAN = $signed({4'b0, bmg_pkg::turn_atan(r)});
      logic signed [33:0] xs;
      logic signed [33:0] ys;

      assign xs = cx[r] >>> r;
      assign ys = cy[r] >>> r;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz[r][33]) begin
            cx[r+1] <= cx[r] - ys;
            cy[r+1] <= cy[r] + xs;
            cz[r+1] <= cz[r] - ATAN;
          end else begin
            cx[r+1] <= cx[r] + ys;
            cy[r+1] <= cy[r] - xs;
            cz[r+1] <= cz[r] + ATAN;
          end
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          cx[r+1] <= cx[r];
          cy[r+1] <= cy[r];
          cz[r+1] <= cz[r];
        end
      end
    end
  end

  // -2 ln u1: the logarithm times 2 ln 2, split into two partial products.
  logic [35:0]        t1;
  logic               z1;
  logic [46:0]        plo;
  logic [46:0]        phi;
  logic               z2;
  logic [65:0]        vsum;
  logic signed [33:0] cp [0:SR+2];

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= {lex[LR], 30'b0} - {6'b0, lfr[LR]};
      z1    <= lzr[LR];
      cp[0] <= cng[LR] ? -cx[LR] : cx[LR];
      plo   <= 47'(t1[17:0]) * 47'(bmg_pkg::TWO_LN2_Q28);
      phi   <= 47'(t1[35:18]) * 47'(bmg_pkg::TWO_LN2_Q28);
      z2    <= z1;
      cp[1] <= cp[0];
      cp[2] <= cp[1];
    end
  end

  assign vsum = {1'b0, phi, 18'b0} + 66'(plo) + (66'(1) << 25);

  logic [63:0] srem [0:SR];
  logic [63:0] sres [0:SR];

  always_ff @(posedge clk) begin
    if (en) begin
      srem[0] <= z2 ? 64'd0 : {vsum[65:26], 24'b0};
      sres[0] <= '0;
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < SR; k++) begin : g_sqrt
    localparam logic [63:0] BITK = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = sres[k] + BITK;

    always_ff @(posedge clk) begin
      if (en) begin
        if (srem[k] >= trial) begin
          srem[k+1] <= srem[k] - trial;
          sres[k+1] <= (sres[k] >> 1) + BITK;
        end else begin
          srem[k+1] <= srem[k];
          sres[k+1] <= sres[k] >> 1;
        end
        cp[k+3] <= cp[k+2];
      end
    end
  end

  // Scaling, offset and saturation.
  logic signed [66:0] prod1;
  logic signed [36:0] unit1;
  logic signed [69:0] prod2;
  logic signed [69:0] rnd;
  logic signed [42:0] total;
  logic signed [31:0] sample;
  logic               clip;

  assign prod1 = $signed({1'b0, sres[SR][31:0]}) * cp[SR+2];

  always_ff @(posedge clk) begin
    if (en) begin
      unit1 <= prod1[66:30];
      prod2 <= unit1 * $signed({1'b0, std_deviation});
    end
  end

  assign rnd   = (prod2 + (70'sd1 <<< 27)) >>> 28;
  assign total = 43'(rnd) + 43'(mean_value);

  always_comb begin
    clip   = 1'b0;
    sample = total[31:0];
    if (total > 43'sd2147483647) begin
      sample = 32'sh7FFF_FFFF;
      clip   = 1'b1;
    end else if (total < -43'sd2147483648) begin
      sample = 32'sh8000_0000;
      clip   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.normal_sample <= sample;
      out_data.saturated     <= clip;
    end
  end

endmodule

/* design/bmg_checker.sv */
// Port-level checker for the Box-Muller Gaussian sample unit, with its bind.
module bmg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bmg_pkg::out_item_t out_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.normal_sample == 32'sh7FFF_FFFF) ||
      (out_data.normal_sample == 32'sh8000_0000))
    else $error("saturated flag without limit value");

endmodule

bind box_muller_gaussian_unit bmg_checker u_bmg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
